// File: sv/fscb_pkg.sv
`timescale 1ns / 1ps
// Constants shared by the floppy sector command builder: disk geometry,
// command opcodes and the fixed bytes of the nine-byte command. No dependencies.
package fscb_pkg;

    // Disk geometry
    localparam int TRACK_SECTORS     = 18;
    localparam int HEAD_COUNT        = 2;
    localparam int CYLINDER_COUNT    = 80;
    localparam int SECTOR_BYTES      = 512;

    localparam int PER_CYL      = TRACK_SECTORS * HEAD_COUNT;
    localparam int DISK_SECTORS = PER_CYL * CYLINDER_COUNT;

    // Field widths
    localparam int OP_W    = 2;
    localparam int LBA_W   = 12;
    localparam int REQ_W   = 12;
    localparam int DRV_W   = 2;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 6;
    localparam int XFER_W  = 15;
    localparam int PC_W    = 7;   // holds PER_CYL up to 127
    localparam int REM_W   = 8;   // remainder before correction, below 2*PER_CYL
    localparam int DISK_W  = 16;  // holds DISK_SECTORS

    // Cylinder estimate: lba * CYL_RECIP >> RECIP_SHIFT, low by at most one
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = LBA_W + RECIP_W;
    localparam int CYL_RECIP   = (1 << RECIP_SHIFT) / PER_CYL;

    // Op codes of the request
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;

    // Controller command bytes
    localparam logic [7:0] OPC_READ       = 8'hC6;
    localparam logic [7:0] OPC_WRITE      = 8'hC5;
    localparam logic [7:0] OPC_READ_TRACK = 8'h42;
    localparam logic [7:0] GAP_LEN        = 8'd27;
    localparam logic [7:0] DATA_LEN       = 8'hFF;
    localparam logic [7:0] SIZE_CODE      = 8'($clog2(SECTOR_BYTES / 128));
    localparam logic [7:0] SPT_BYTE       = 8'(TRACK_SECTORS);

    localparam int CMD_LEN = 9;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CMD_LEN - 1);

endpackage

// File: sv/floppy_sector_command_builder.sv
`timescale 1ns / 1ps
// Floppy sector command builder: address split, count clamp and
// nine-byte command serializer. Depends on fscb_pkg.
//
// Usage:
//   Request channel: i_in_valid with i_op, i_block_address, i_requested_count;
//   a beat is taken when i_in_valid is high and o_in_stall is low.
//   Result channel: o_out_valid with the command byte and its tags; a beat is
//   taken when o_out_valid is high and i_out_stall is low. Nine beats per
//   request, byte_index 0 to 8, o_last on the ninth.
//   Config: i_cfg_wr_en writes the drive number from i_cfg_wr_data; write only
//   while no request is in flight.
// Pipeline:
//   Three compute stages (cylinder estimate, remainder correction, head/sector
//   and count clamp) feed a nine-entry byte shift register. The first byte
//   shows once the request has passed the three compute stages. New requests
//   are taken while the serializer still sends an earlier one: up to three
//   more queue in the compute stages while the serializer drains.
// Reset (synchronous, active low) empties all stages and clears the drive
// number. When the receiver stalls, the current byte holds and the stages
// fill, then o_in_stall rises; nothing is lost or repeated.
module floppy_sector_command_builder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [fscb_pkg::DRV_W-1:0]      i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [fscb_pkg::OP_W-1:0]       i_op,
    input  logic [fscb_pkg::LBA_W-1:0]      i_block_address,
    input  logic [fscb_pkg::REQ_W-1:0]      i_requested_count,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_cmd_byte,
    output logic [fscb_pkg::IDX_W-1:0]      o_byte_index,
    output logic [fscb_pkg::CNT_W-1:0]      o_sector_count,
    output logic [fscb_pkg::XFER_W-1:0]     o_transfer_bytes,
    output logic                            o_range_error,
    output logic                            o_last
);

    logic [fscb_pkg::DRV_W-1:0] r_drive_select;

    // Stage A: request plus cylinder estimate
    logic                            r_a_valid;
    logic [fscb_pkg::OP_W-1:0]       r_a_op;
    logic [fscb_pkg::LBA_W-1:0]      r_a_lba;
    logic [fscb_pkg::REQ_W-1:0]      r_a_req;
    logic [fscb_pkg::LBA_W-1:0]      r_a_cyl;

    // Stage B: exact cylinder and offset within it
    logic                            r_b_valid;
    logic [fscb_pkg::OP_W-1:0]       r_b_op;
    logic [fscb_pkg::LBA_W-1:0]      r_b_lba;
    logic [fscb_pkg::REQ_W-1:0]      r_b_req;
    logic [fscb_pkg::LBA_W-1:0]      r_b_cyl;
    logic [fscb_pkg::PC_W-1:0]       r_b_rem;

    // Stage C: command fields
    logic                            r_c_valid;
    logic [7:0]                      r_c_opcode;
    logic                            r_c_head;
    logic [7:0]                      r_c_cyl;
    logic [7:0]                      r_c_sect;
    logic [fscb_pkg::PC_W-1:0]       r_c_count;
    logic                            r_c_err;

    // Stage D: serializer
    logic                            r_d_valid;
    logic [7:0]                      r_bytes [fscb_pkg::CMD_LEN];
    logic [fscb_pkg::IDX_W-1:0]      r_idx;
    logic [fscb_pkg::CNT_W-1:0]      r_cnt;
    logic [fscb_pkg::XFER_W-1:0]     r_xfer;
    logic                            r_err;

    logic out_fire, d_ready, c_ready, b_ready, a_ready;

    assign out_fire = r_d_valid && !i_out_stall;
    assign d_ready  = !r_d_valid || (out_fire && (r_idx == fscb_pkg::LAST_IDX));
    assign c_ready  = !r_c_valid || d_ready;
    assign b_ready  = !r_b_valid || c_ready;
    assign a_ready  = !r_a_valid || b_ready;
    assign o_in_stall = !a_ready;

    // Stage A logic
    logic [fscb_pkg::PROD_W-1:0] a_prod;
    assign a_prod = fscb_pkg::PROD_W'(i_block_address) *
                    fscb_pkg::PROD_W'(fscb_pkg::CYL_RECIP);

    // Stage B logic
    logic [fscb_pkg::LBA_W+fscb_pkg::PC_W-1:0] b_base;
    logic [fscb_pkg::REM_W-1:0]                b_rem0;
    logic                                      b_fix;
    assign b_base = (fscb_pkg::LBA_W+fscb_pkg::PC_W)'(r_a_cyl) *
                    (fscb_pkg::LBA_W+fscb_pkg::PC_W)'(fscb_pkg::PER_CYL);
    assign b_rem0 = fscb_pkg::REM_W'(r_a_lba - b_base[fscb_pkg::LBA_W-1:0]);
    assign b_fix  = b_rem0 >= fscb_pkg::REM_W'(fscb_pkg::PER_CYL);

    // Stage C logic
    logic                        c_head;
    logic [7:0]                  c_sect;
    logic [fscb_pkg::PC_W-1:0]   c_room;
    logic [fscb_pkg::PC_W-1:0]   c_count;
    logic                        c_err;
    logic                        c_track;
    logic [7:0]                  c_opcode;
    always_comb begin
        c_head  = r_b_rem >= fscb_pkg::PC_W'(fscb_pkg::TRACK_SECTORS);
        c_sect  = 8'(r_b_rem) + 8'd1
                  - (c_head ? fscb_pkg::SPT_BYTE : 8'd0);
        c_room  = fscb_pkg::PC_W'(fscb_pkg::PER_CYL) - r_b_rem;
        c_track = r_b_op[1];
        c_err   = fscb_pkg::DISK_W'(r_b_lba) >= fscb_pkg::DISK_W'(fscb_pkg::DISK_SECTORS);
        if (c_track) begin
            c_count  = fscb_pkg::PC_W'(fscb_pkg::PER_CYL);
            c_opcode = fscb_pkg::OPC_READ_TRACK;
        end else begin
            c_count  = (r_b_req < fscb_pkg::REQ_W'(c_room)) ?
                       fscb_pkg::PC_W'(r_b_req) : c_room;
            c_opcode = (r_b_op == fscb_pkg::OP_WRITE) ? fscb_pkg::OPC_WRITE
                                                      : fscb_pkg::OPC_READ;
        end
        if (c_err) begin
            c_count = '0;
        end
    end

    // Stage D load values
    logic [fscb_pkg::PC_W+11-1:0] d_xfer;
    assign d_xfer = (fscb_pkg::PC_W+11)'(r_c_count) *
                    (fscb_pkg::PC_W+11)'(fscb_pkg::SECTOR_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_select <= '0;
        end else if (i_cfg_wr_en) begin
            r_drive_select <= i_cfg_wr_data;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
            if (d_ready) begin
                r_d_valid <= r_c_valid;
                r_idx     <= '0;
            end else if (out_fire) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_op  <= i_op;
            r_a_lba <= i_block_address;
            r_a_req <= i_requested_count;
            r_a_cyl <= a_prod[fscb_pkg::RECIP_SHIFT +: fscb_pkg::LBA_W];
        end
        if (b_ready) begin
            r_b_op  <= r_a_op;
            r_b_lba <= r_a_lba;
            r_b_req <= r_a_req;
            if (b_fix) begin
                r_b_cyl <= r_a_cyl + 1'b1;
                r_b_rem <= fscb_pkg::PC_W'(b_rem0 - fscb_pkg::REM_W'(fscb_pkg::PER_CYL));
            end else begin
                r_b_cyl <= r_a_cyl;
                r_b_rem <= fscb_pkg::PC_W'(b_rem0);
            end
        end
        if (c_ready) begin
            r_c_opcode <= c_opcode;
            r_c_head   <= c_head;
            r_c_cyl    <= r_b_cyl[7:0];
            r_c_sect   <= c_sect;
            r_c_count  <= c_count;
            r_c_err    <= c_err;
        end
        if (d_ready) begin
            r_bytes[0] <= r_c_opcode;
            r_bytes[1] <= {5'd0, r_c_head, r_drive_select};
            r_bytes[2] <= r_c_cyl;
            r_bytes[3] <= {7'd0, r_c_head};
            r_bytes[4] <= r_c_sect;
            r_bytes[5] <= fscb_pkg::SIZE_CODE;
            r_bytes[6] <= fscb_pkg::SPT_BYTE;
            r_bytes[7] <= fscb_pkg::GAP_LEN;
            r_bytes[8] <= fscb_pkg::DATA_LEN;
            r_cnt      <= r_c_count[fscb_pkg::CNT_W-1:0];
            r_xfer     <= d_xfer[fscb_pkg::XFER_W-1:0];
            r_err      <= r_c_err;
        end else if (out_fire) begin
            // shift the next byte to the head of the line
            for (int k = 0; k < fscb_pkg::CMD_LEN - 1; k++) begin
                r_bytes[k] <= r_bytes[k+1];
            end
        end
    end

    assign o_out_valid      = r_d_valid;
    assign o_cmd_byte       = r_bytes[0];
    assign o_byte_index     = r_idx;
    assign o_sector_count   = r_cnt;
    assign o_transfer_bytes = r_xfer;
    assign o_range_error    = r_err;
    assign o_last           = (r_idx == fscb_pkg::LAST_IDX);

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for floppy_sector_command_builder: random and directed transfer requests,
// a scoreboard that predicts the nine command beats of each one, random request gaps and output stalls.
// Depends on fscb_pkg and the builder RTL.
module tb;
    import fscb_pkg::*;

    // read track is selected by op bit 1; op 3 is the undefined code
    localparam logic [OP_W-1:0] OP_TRACK     = 2'd2;
    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;
    localparam logic [DRV_W-1:0] DRIVE_MIN   = 2'd0;
    localparam logic [DRV_W-1:0] DRIVE_MAX   = 2'd3;

    typedef struct packed {
        logic [7:0]        cmd;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  cnt;
        logic [XFER_W-1:0] xfer;
        logic              err;
        logic              last;
    } t_cmd_beat;

    class t_cmd_scoreboard;
        t_cmd_beat          pending_q[$];
        logic [DRV_W-1:0]   drive;
        int                 errors;
        int                 n_requests;
        int                 n_beats;
        int                 n_range_err;
        int                 n_track;
        int                 n_clamped;

        function new();
            drive = DRIVE_MIN;
            errors = 0;
            n_requests = 0;
            n_beats = 0;
            n_range_err = 0;
            n_track = 0;
            n_clamped = 0;
        endfunction

        // Predict the nine command beats of one accepted request.
        function void note_request(logic [OP_W-1:0] op, logic [LBA_W-1:0] lba,
                                   logic [REQ_W-1:0] req);
            int unsigned cyl, head, sect, room, count, xfer, code, sz;
            logic [7:0]  cmd_bytes[CMD_LEN];
            bit          track, err;
            t_cmd_beat   b;
            cyl   = lba / PER_CYL;
            head  = (lba / TRACK_SECTORS) % HEAD_COUNT;
            sect  = lba % TRACK_SECTORS + 1;
            track = op[1];
            err   = lba >= DISK_SECTORS;
            code  = 0;
            sz    = SECTOR_BYTES;
            while (sz > 128 && code < 7) begin
                sz = sz >> 1;
                code++;
            end
            if (track) begin
                count = PER_CYL;
                cmd_bytes[0] = OPC_READ_TRACK;
                n_track++;
            end else begin
                room  = PER_CYL - lba % PER_CYL;
                count = (req < room) ? req : room;
                if (req > room)
                    n_clamped++;
                cmd_bytes[0] = (op == OP_WRITE) ? OPC_WRITE : OPC_READ;
            end
            if (err) begin
                count = 0;
                n_range_err++;
            end
            xfer = count * SECTOR_BYTES;
            cmd_bytes[1] = 8'(drive | (head << 2));
            cmd_bytes[2] = 8'(cyl);
            cmd_bytes[3] = 8'(head);
            cmd_bytes[4] = 8'(sect);
            cmd_bytes[5] = 8'(code);
            cmd_bytes[6] = 8'(TRACK_SECTORS);
            cmd_bytes[7] = GAP_LEN;
            cmd_bytes[8] = DATA_LEN;
            for (int k = 0; k < CMD_LEN; k++) begin
                b.cmd  = cmd_bytes[k];
                b.idx  = IDX_W'(k);
                b.cnt  = CNT_W'(count);
                b.xfer = XFER_W'(xfer);
                b.err  = err;
                b.last = (k == CMD_LEN - 1);
                pending_q.push_back(b);
            end
            n_requests++;
        endfunction

        function void compare_field(string name, int unsigned idx, int unsigned exp_v,
                                    int unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch on byte %0d: expected 0x%0h, actual 0x%0h",
                         $time, name, idx, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_beat(t_cmd_beat got);
            t_cmd_beat exp_b;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected beat: expected none, actual byte 0x%0h index %0d",
                         $time, got.cmd, got.idx);
                errors++;
                return;
            end
            exp_b = pending_q.pop_front();
            n_beats++;
            compare_field("cmd_byte",       exp_b.idx, exp_b.cmd,  got.cmd);
            compare_field("byte_index",     exp_b.idx, exp_b.idx,  got.idx);
            compare_field("sector_count",   exp_b.idx, exp_b.cnt,  got.cnt);
            compare_field("transfer_bytes", exp_b.idx, exp_b.xfer, got.xfer);
            compare_field("range_error",    exp_b.idx, exp_b.err,  got.err);
            compare_field("last",           exp_b.idx, exp_b.last, got.last);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [DRV_W-1:0]    i_cfg_wr_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_op;
    logic [LBA_W-1:0]    i_block_address;
    logic [REQ_W-1:0]    i_requested_count;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [7:0]          o_cmd_byte;
    logic [IDX_W-1:0]    o_byte_index;
    logic [CNT_W-1:0]    o_sector_count;
    logic [XFER_W-1:0]   o_transfer_bytes;
    logic                o_range_error;
    logic                o_last;

    t_cmd_scoreboard board = new();
    bit              tx_steady;
    bit              rx_steady;

    floppy_sector_command_builder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_block_address   (i_block_address),
        .i_requested_count (i_requested_count),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_cmd_byte        (o_cmd_byte),
        .o_byte_index      (o_byte_index),
        .o_sector_count    (o_sector_count),
        .o_transfer_bytes  (o_transfer_bytes),
        .o_range_error     (o_range_error),
        .o_last            (o_last)
    );

    always #1 i_clk = ~i_clk;

    // All tasks are entered and left in the time step of a rising edge.
    task automatic send_request(logic [OP_W-1:0] op, logic [LBA_W-1:0] lba,
                                logic [REQ_W-1:0] req);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_op              <= op;
        i_block_address   <= lba;
        i_requested_count <= req;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(op, lba, req);
    endtask

    task automatic send_random_request();
        logic [OP_W-1:0]  op;
        logic [LBA_W-1:0] lba;
        logic [REQ_W-1:0] req;
        int               pick;
        op   = OP_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            lba = LBA_W'($urandom_range(0, 4095));
        else if (pick == 1)   // last sectors of a cylinder, where the clamp bites
            lba = LBA_W'($urandom_range(0, CYLINDER_COUNT - 1) * PER_CYL + PER_CYL
                         - $urandom_range(1, 3));
        else
            lba = LBA_W'($urandom_range(0, DISK_SECTORS - 1));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            req = REQ_W'($urandom_range(0, 4095));
        else if (pick == 1)
            req = '0;
        else
            req = REQ_W'($urandom_range(1, PER_CYL + 4));
        send_request(op, lba, req);
    endtask

    // Block goes quiet: every request yields beats, so an empty queue means idle.
    task automatic wait_all_beats();
        i_in_valid <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_drive(logic [DRV_W-1:0] drv);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= drv;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        board.drive = drv;
    endtask

    // Receiver: per beat, hold stall for a random number of cycles, none when rx_steady is set.
    initial begin
        int hold;
        forever begin
            hold = rx_steady ? 0 : $urandom_range(0, 16);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_beat({o_cmd_byte, o_byte_index, o_sector_count, o_transfer_bytes,
                              o_range_error, o_last});
    end

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_wr_en       <= 1'b0;
        i_cfg_wr_data     <= '0;
        i_in_valid        <= 1'b0;
        i_op              <= '0;
        i_block_address   <= '0;
        i_requested_count <= '0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, every op, cylinder edges, out of range, zero count.
        write_drive(DRIVE_MAX);
        send_request(OP_READ,      12'd0,    12'd1);
        send_request(OP_WRITE,     12'd0,    12'd36);
        send_request(OP_READ,      12'd0,    12'd4095);
        send_request(OP_WRITE,     12'd35,   12'd4095);
        send_request(OP_READ,      12'd17,   12'd5);
        send_request(OP_READ,      12'd18,   12'd40);
        send_request(OP_WRITE,     12'd36,   12'd0);
        send_request(OP_TRACK,     12'd0,    12'd0);
        send_request(OP_UNDEFINED, 12'd100,  12'd7);
        send_request(OP_TRACK,     12'd2879, 12'd4095);
        send_request(OP_READ,      12'd2879, 12'd2);
        send_request(OP_WRITE,     12'd2878, 12'd4095);
        send_request(OP_WRITE,     12'd2880, 12'd5);
        send_request(OP_TRACK,     12'd2880, 12'd0);
        send_request(OP_READ,      12'd4095, 12'd4095);
        send_request(OP_UNDEFINED, 12'd4095, 12'd0);
        send_request(OP_READ,      12'd100,  12'hAAA);
        send_request(OP_WRITE,     12'h555,  12'h555);
        send_request(OP_READ,      12'hAAA,  12'd3);
        wait_all_beats();

        // Random phases under different drive numbers and idling patterns.
        write_drive(DRIVE_MIN);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (35) send_random_request();
        wait_all_beats();

        write_drive(2'd1);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (35) send_random_request();
        wait_all_beats();

        write_drive(2'd2);
        tx_steady = 1'b1;
        rx_steady = 1'b0;
        repeat (35) send_random_request();
        wait_all_beats();

        write_drive(DRIVE_MAX);
        tx_steady = 1'b0;
        rx_steady = 1'b1;
        repeat (35) send_random_request();
        wait_all_beats();

        // catch any stray beat after the last one
        repeat (30) @(posedge i_clk);
        $display("Covered %0d requests (%0d read track, %0d clamped, %0d out of range),",
                 board.n_requests, board.n_track, board.n_clamped, board.n_range_err);
        $display("%0d command beats checked across all four drive numbers.", board.n_beats);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #1000000;
        $display("Timeout with %0d beats still expected", board.pending_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule
